// File: sv/csdm_pkg.sv
// Package for the concentric square-to-disk map: widths, constants, item types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package csdm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 18;
    localparam int GUARD        = 4;
    localparam int ANGLE_BITS   = 30;
    localparam int FIFO_DEPTH   = 4;

    localparam int IN_W      = FRAC_BITS + 1;
    localparam int OUT_W     = FRAC_BITS + 2;
    localparam int SQ_W      = FRAC_BITS + 2;
    localparam int MAG_W     = FRAC_BITS + 1;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int DVD_W     = 2 * FRAC_BITS + 2;
    localparam int XY_W      = FRAC_BITS + GUARD + 3;
    localparam int Z_W       = ANGLE_BITS + 2;
    localparam int SC_W      = XY_W + 1 - GUARD;
    localparam int TDATA_IN_W  = ((2 * IN_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((2 * OUT_W + 7) / 8) * 8;

    localparam longint ONE      = longint'(1) << FRAC_BITS;
    localparam longint PI4_Q30  = 843314857;
    localparam longint GAIN_Q30 = 652032874;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } t_quad;

    typedef struct packed {
        logic [MAG_W-1:0] rad;
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] den;
        logic             neg;
        t_quad            quad;
    } t_item;

    function automatic logic [ANGLE_BITS-1:0] atan_q30(input int i);
        logic [ANGLE_BITS-1:0] v;
        case (i)
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            default: v = (i < ANGLE_BITS) ? (ANGLE_BITS'(1) << (ANGLE_BITS - i)) : '0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/csdm_front.sv
// Front stage: clamp the square point, recentre it and pick the region.
// Depends on csdm_pkg.
`timescale 1ns / 1ps

module csdm_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [csdm_pkg::IN_W-1:0] i_x,
    input  logic [csdm_pkg::IN_W-1:0] i_y,
    input  logic                    i_full,
    output logic                    o_push,
    output csdm_pkg::t_item         o_item
);
    import csdm_pkg::*;

    logic                   r_valid;
    t_item                  r_item;
    t_item                  n_item;
    logic [IN_W-1:0]        w_xs, w_ys;
    logic signed [SQ_W:0]   w_a_ext, w_b_ext, w_sum;
    logic signed [SQ_W-1:0] w_a, w_b;
    logic [SQ_W-1:0]        w_a_abs, w_b_abs;
    logic [MAG_W-1:0]       w_ma, w_mb;

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign o_item  = r_item;

    always_comb begin
        w_xs    = (i_x > IN_W'(ONE)) ? IN_W'(ONE) : i_x;
        w_ys    = (i_y > IN_W'(ONE)) ? IN_W'(ONE) : i_y;
        w_a_ext = $signed({1'b0, w_xs, 1'b0}) - $signed((SQ_W+1)'(ONE));
        w_b_ext = $signed({1'b0, w_ys, 1'b0}) - $signed((SQ_W+1)'(ONE));
        w_a     = w_a_ext[SQ_W-1:0];
        w_b     = w_b_ext[SQ_W-1:0];
        w_sum   = w_a_ext + w_b_ext;
        w_a_abs = w_a[SQ_W-1] ? SQ_W'(-w_a) : SQ_W'(w_a);
        w_b_abs = w_b[SQ_W-1] ? SQ_W'(-w_b) : SQ_W'(w_b);
        w_ma    = w_a_abs[MAG_W-1:0];
        w_mb    = w_b_abs[MAG_W-1:0];
        if (w_sum > 0) begin
            if (w_a > w_b) begin
                n_item = '{rad: w_ma, num: w_mb, den: w_ma, neg: w_b < 0, quad: QUAD_0};
            end else begin
                n_item = '{rad: w_mb, num: w_ma, den: w_mb, neg: w_a > 0, quad: QUAD_90};
            end
        end else begin
            if (w_a < w_b) begin
                n_item = '{rad: w_ma, num: w_mb, den: w_ma, neg: w_b > 0, quad: QUAD_180};
            end else if (w_b != 0) begin
                n_item = '{rad: w_mb, num: w_ma, den: w_mb, neg: w_a < 0, quad: QUAD_270};
            end else begin
                // origin: force a zero ratio
                n_item = '{rad: '0, num: '0, den: MAG_W'(1), neg: 1'b0, quad: QUAD_270};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// File: sv/csdm_fifo.sv
// Short queue between front and back stages.
// Depends on csdm_pkg.
`timescale 1ns / 1ps

module csdm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  csdm_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_avail,
    output csdm_pkg::t_item o_item
);
    import csdm_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PTR_W'(1);
            if (i_pop)  r_rd <= r_rd + PTR_W'(1);
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

// File: sv/csdm_back.sv
// Back stages: pipelined ratio divider, angle scaling, CORDIC rotation,
// gain correction, saturation and quadrant turn. Depends on csdm_pkg.
`timescale 1ns / 1ps

module csdm_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_avail,
    input  csdm_pkg::t_item          i_item,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [csdm_pkg::OUT_W-1:0] o_u,
    output logic [csdm_pkg::OUT_W-1:0] o_v
);
    import csdm_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] rad;
        logic             neg;
        t_quad            quad;
    } t_ctl;

    localparam int PR_W = MAG_W + ANGLE_BITS;
    localparam int MP_W = XY_W + ANGLE_BITS + 1;

    logic w_adv;

    // divider stages, index 0 is the prepared dividend
    logic                 r_d_vld [DIV_STEPS+1];
    logic [MAG_W-1:0]     r_d_rem [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_d_low [DIV_STEPS+1];
    logic [MAG_W-1:0]     r_d_den [DIV_STEPS+1];
    logic [MAG_W-1:0]     r_d_quo [DIV_STEPS+1];
    t_ctl                 r_d_ctl [DIV_STEPS+1];

    // CORDIC stages, index 0 is the start vector
    logic                   r_c_vld  [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] r_c_x    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] r_c_y    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  r_c_z    [CORDIC_STEPS+1];
    t_quad                  r_c_quad [CORDIC_STEPS+1];

    logic                   r_s_vld;
    logic signed [SC_W-1:0] r_s_u, r_s_v;
    t_quad                  r_s_quad;

    logic                   r_o_vld;
    logic [OUT_W-1:0]       r_o_u, r_o_v;

    logic [DVD_W-1:0]       w_dvd;
    logic [PR_W-1:0]        w_th_prod;
    logic [Z_W-2:0]         w_zmag;
    logic signed [MP_W-1:0] w_pu, w_pv;
    logic signed [OUT_W-1:0] w_su, w_sv, n_u, n_v;

    assign w_adv   = !r_o_vld || i_ready;
    assign o_pop   = w_adv && i_avail;
    assign o_valid = r_o_vld;
    assign o_u     = r_o_u;
    assign o_v     = r_o_v;

    // dividend: num * ONE + den / 2
    assign w_dvd = (DVD_W'(i_item.num) << FRAC_BITS) + DVD_W'(i_item.den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_d_vld[0] <= i_avail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_rem[0] <= w_dvd[DVD_W-1:DIV_STEPS];
            r_d_low[0] <= w_dvd[DIV_STEPS-1:0];
            r_d_den[0] <= i_item.den;
            r_d_quo[0] <= '0;
            r_d_ctl[0] <= '{rad: i_item.rad, neg: i_item.neg, quad: i_item.quad};
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        logic [MAG_W:0] w_trial;
        logic           w_ge;
        assign w_trial = {r_d_rem[s], r_d_low[s][DIV_STEPS-1-s]};
        assign w_ge    = (w_trial >= {1'b0, r_d_den[s]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[s+1] <= 1'b0;
            end else if (w_adv) begin
                r_d_vld[s+1] <= r_d_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d_rem[s+1] <= w_ge ? MAG_W'(w_trial - {1'b0, r_d_den[s]})
                                     : w_trial[MAG_W-1:0];
                r_d_low[s+1] <= r_d_low[s];
                r_d_den[s+1] <= r_d_den[s];
                r_d_quo[s+1] <= {r_d_quo[s][MAG_W-2:0], w_ge};
                r_d_ctl[s+1] <= r_d_ctl[s];
            end
        end
    end

    // angle in Q.30 radians, ties rounded up
    assign w_th_prod = PR_W'(r_d_quo[DIV_STEPS]) * PR_W'(PI4_Q30) + PR_W'(ONE >> 1);
    assign w_zmag    = w_th_prod[FRAC_BITS +: (Z_W-1)];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_c_vld[0] <= r_d_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_x[0]    <= $signed(XY_W'({r_d_ctl[DIV_STEPS].rad, GUARD'(0)}));
            r_c_y[0]    <= '0;
            r_c_z[0]    <= r_d_ctl[DIV_STEPS].neg ? -$signed({1'b0, w_zmag})
                                                 : $signed({1'b0, w_zmag});
            r_c_quad[0] <= r_d_ctl[DIV_STEPS].quad;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [XY_W-1:0] w_dx, w_dy;
        logic signed [Z_W-1:0]  w_at;
        assign w_dx = r_c_y[i] >>> i;
        assign w_dy = r_c_x[i] >>> i;
        assign w_at = $signed(Z_W'(atan_q30(i)));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[i+1] <= 1'b0;
            end else if (w_adv) begin
                r_c_vld[i+1] <= r_c_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_c_z[i] >= 0) begin
                    r_c_x[i+1] <= r_c_x[i] - w_dx;
                    r_c_y[i+1] <= r_c_y[i] + w_dy;
                    r_c_z[i+1] <= r_c_z[i] - w_at;
                end else begin
                    r_c_x[i+1] <= r_c_x[i] + w_dx;
                    r_c_y[i+1] <= r_c_y[i] - w_dy;
                    r_c_z[i+1] <= r_c_z[i] + w_at;
                end
                r_c_quad[i+1] <= r_c_quad[i];
            end
        end
    end

    // gain correction with rounding
    assign w_pu = MP_W'(r_c_x[CORDIC_STEPS]) * $signed(MP_W'(GAIN_Q30))
                + $signed(MP_W'(longint'(1) << (ANGLE_BITS + GUARD - 1)));
    assign w_pv = MP_W'(r_c_y[CORDIC_STEPS]) * $signed(MP_W'(GAIN_Q30))
                + $signed(MP_W'(longint'(1) << (ANGLE_BITS + GUARD - 1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (w_adv) begin
            r_s_vld <= r_c_vld[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_u    <= w_pu[MP_W-1:ANGLE_BITS+GUARD];
            r_s_v    <= w_pv[MP_W-1:ANGLE_BITS+GUARD];
            r_s_quad <= r_c_quad[CORDIC_STEPS];
        end
    end

    // saturate, then turn by the quadrant
    always_comb begin
        if (r_s_u > $signed(SC_W'(ONE)))       w_su = OUT_W'(ONE);
        else if (r_s_u < -$signed(SC_W'(ONE))) w_su = -$signed(OUT_W'(ONE));
        else                                   w_su = r_s_u[OUT_W-1:0];
        if (r_s_v > $signed(SC_W'(ONE)))       w_sv = OUT_W'(ONE);
        else if (r_s_v < -$signed(SC_W'(ONE))) w_sv = -$signed(OUT_W'(ONE));
        else                                   w_sv = r_s_v[OUT_W-1:0];
        case (r_s_quad)
            QUAD_90: begin
                n_u = -w_sv;
                n_v = w_su;
            end
            QUAD_180: begin
                n_u = -w_su;
                n_v = -w_sv;
            end
            QUAD_270: begin
                n_u = w_sv;
                n_v = -w_su;
            end
            default: begin
                n_u = w_su;
                n_v = w_sv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_u <= n_u;
            r_o_v <= n_v;
        end
    end

endmodule

// File: sv/concentric_square_to_disk_map.sv
// Top level of the concentric square-to-disk map: front stage, queue, back pipeline.
// Depends on csdm_pkg, csdm_front, csdm_fifo and csdm_back.
//
// Usage:
//   Slave stream s_axis carries one square point per beat: tdata holds
//   x_on_square in bits [16:0] and y_on_square in bits [33:17], both unsigned
//   Q1.16 with 65536 = 1.0; larger values are clamped to 1.0.
//   Master stream m_axis returns one disk point per beat: u_on_disk in bits
//   [17:0] and v_on_disk in bits [35:18], two's complement Q.16 in [-1.0, 1.0].
//   Throughput is one beat per cycle while m_axis_tready stays high: the divider
//   and the CORDIC are fully pipelined, one stage per quotient bit and one per rotation step.
//   From input beat to output beat a point passes one front register, one
//   in the queue, a prepare stage, 17 divider stages, the angle stage,
//   18 rotation stages, the gain stage and the output register.
//   Reset (i_rst_n low at a clock edge) empties every stage and the queue;
//   data in flight is dropped. When the receiver holds tready low the back
//   pipeline freezes, the four-entry queue fills up, and then s_axis_tready
//   falls; no beat is lost or repeated.
`timescale 1ns / 1ps

module concentric_square_to_disk_map (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [16:0] x_on_square, [33:17] y_on_square, rest zero
    input  logic [csdm_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [17:0] u_on_disk, [35:18] v_on_disk, rest zero
    output logic [csdm_pkg::TDATA_OUT_W-1:0]     m_axis_tdata
);
    import csdm_pkg::*;

    logic             w_push, w_full, w_pop, w_avail;
    t_item            w_front_item, w_queue_item;
    logic [OUT_W-1:0] w_u, w_v;

    csdm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[IN_W-1:0]),
        .i_y     (s_axis_tdata[2*IN_W-1:IN_W]),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    // decouple classification from the long arithmetic pipeline
    csdm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_item  (w_queue_item)
    );

    csdm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_item  (w_queue_item),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_u     (w_u),
        .o_v     (w_v)
    );

    // pad the packed result to whole bytes
    assign m_axis_tdata = {(TDATA_OUT_W - 2*OUT_W)'(0), w_v, w_u};

endmodule

// File: sim/concentric_square_to_disk_map_test.sv
// Testbench for the concentric square-to-disk map: drives square points, predicts disk points.
// Depends on csdm_pkg and concentric_square_to_disk_map.
`timescale 1ns / 1ps

module concentric_square_to_disk_map_test;
    import csdm_pkg::*;

    localparam int LATENCY = 41;

    typedef struct packed {
        logic [OUT_W-1:0] v_on_disk;
        logic [OUT_W-1:0] u_on_disk;
    } t_disk_pt;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [16:0] x_on_square, [33:17] y_on_square, rest zero
    logic [TDATA_IN_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [17:0] u_on_disk, [35:18] v_on_disk, rest zero
    logic [TDATA_OUT_W-1:0] m_axis_tdata;

    t_disk_pt disk_pts_due[$];
    int       mismatches;
    int       send_idle_pct;
    int       recv_stall_pct;

    concentric_square_to_disk_map uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous limit: 1600-odd beats at worst pressure are far below this.
    initial begin
        #20ms;
        $display("concentric_square_to_disk_map: mismatch");
        $finish;
    end

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint quot_rounded(input longint num, input longint den);
        longint n, d, q;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        if (d == 0)
            return 0;
        q = ((n << FRAC_BITS) + (d >> 1)) / d;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic longint gain_clip(input longint w);
        longint p;
        p = floor_shr(w * GAIN_Q30 + (longint'(1) << (ANGLE_BITS + GUARD - 1)),
                      ANGLE_BITS + GUARD);
        if (p > ONE)
            return ONE;
        if (p < -ONE)
            return -ONE;
        return p;
    endfunction

    // Map one square point onto the disk exactly as the hardware rounds it.
    function automatic t_disk_pt disk_point(input logic [IN_W-1:0] xq, input logic [IN_W-1:0] yq);
        longint xs, ys, a, b, r, t, z, x, y, dx, dy, u, v, ru, rv;
        t_quad  quad;
        t_disk_pt pt;
        xs = (xq > ONE) ? ONE : longint'(xq);
        ys = (yq > ONE) ? ONE : longint'(yq);
        a = 2 * xs - ONE;
        b = 2 * ys - ONE;
        if (a > -b) begin
            if (a > b) begin
                r = a; quad = QUAD_0; t = quot_rounded(b, a);
            end else begin
                r = b; quad = QUAD_90; t = -quot_rounded(a, b);
            end
        end else begin
            if (a < b) begin
                r = -a; quad = QUAD_180; t = quot_rounded(b, a);
            end else begin
                r = -b; quad = QUAD_270; t = (b != 0) ? -quot_rounded(a, b) : 0;
            end
        end
        z = (((t < 0) ? -t : t) * PI4_Q30 + (ONE >> 1)) >>> FRAC_BITS;
        if (t < 0)
            z = -z;
        x = r << GUARD;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_q30(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_q30(i));
            end
        end
        u = gain_clip(x);
        v = gain_clip(y);
        case (quad)
            QUAD_90:  begin ru = -v; rv = u;  end
            QUAD_180: begin ru = -u; rv = -v; end
            QUAD_270: begin ru = v;  rv = -u; end
            default:  begin ru = u;  rv = v;  end
        endcase
        pt.u_on_disk = ru[OUT_W-1:0];
        pt.v_on_disk = rv[OUT_W-1:0];
        return pt;
    endfunction

    // Send one point; predict it at the edge that accepts it.
    // Hold tvalid high afterwards so the next call can follow without a gap.
    task automatic send_point(input logic [IN_W-1:0] xq, input logic [IN_W-1:0] yq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_IN_W - 2 * IN_W){1'b0}}, yq, xq};
        do @(posedge i_clk); while (!s_axis_tready);
        disk_pts_due.push_back(disk_point(xq, yq));
    endtask

    // Receiver: stall at random and check each beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_disk_pt got, want;
            got = m_axis_tdata[2*OUT_W-1:0];
            if (disk_pts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat u=%h v=%h", got.u_on_disk, got.v_on_disk);
            end else begin
                want = disk_pts_due.pop_front();
                if (got.u_on_disk !== want.u_on_disk || got.v_on_disk !== want.v_on_disk) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("disk point: expected u=%h v=%h, got u=%h v=%h",
                                 want.u_on_disk, want.v_on_disk, got.u_on_disk, got.v_on_disk);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Drop tvalid and wait until every predicted beat has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (disk_pts_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Corners, edges, centre, clamped values and all four regions with their borders.
    task automatic test_directed();
        logic [IN_W-1:0] pts[20][2];
        pts = '{'{0, 0}, '{65536, 65536}, '{0, 65536}, '{65536, 0}, '{32768, 32768},
                '{131071, 131071}, '{131071, 0}, '{0, 131071}, '{65537, 32768},
                '{49152, 32768}, '{32768, 49152}, '{16384, 32768}, '{32768, 16384},
                '{49152, 49152}, '{16384, 49152}, '{16384, 16384}, '{49152, 16384},
                '{32769, 32768}, '{32768, 32767}, '{65535, 1}};
        foreach (pts[i])
            send_point(pts[i][0], pts[i][1]);
        drain();
    endtask

    // Mostly in range points, some clamped, some near the centre.
    task automatic test_random(input int count);
        logic [IN_W-1:0] xq, yq;
        repeat (count) begin
            case ($urandom_range(9))
                0: begin
                    xq = IN_W'($urandom);
                    yq = IN_W'($urandom);
                end
                1: begin
                    xq = IN_W'(32768 + $urandom_range(8) - 4);
                    yq = IN_W'(32768 + $urandom_range(8) - 4);
                end
                default: begin
                    xq = IN_W'($urandom_range(65536));
                    yq = IN_W'($urandom_range(65536));
                end
            endcase
            send_point(xq, yq);
        end
        drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        send_idle_pct = 57;
        test_random(400);
        send_idle_pct = 0;  recv_stall_pct = 57;
        test_random(400);
        send_idle_pct = 12; recv_stall_pct = 12;
        test_random(400);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && disk_pts_due.size() == 0)
            $display("concentric_square_to_disk_map: match");
        else
            $display("concentric_square_to_disk_map: mismatch");
        $finish;
    end

endmodule
